[rtl/asc_pkg.sv]
// Shared types and constants for the audio sync sample compensator.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package asc_pkg;

	localparam int TS_W   = 40;
	localparam int MS_W   = 32;
	localparam int FRM_W  = 14;
	localparam int OUT_W  = 14;
	localparam int CFG_W  = 32;
	localparam int RATE_W = 18;
	localparam int DIFF_W = 48;
	localparam int SUM_W  = 56;

	localparam int DEF_MAX_FRAME_SAMPLES = 8192;
	localparam int DEF_MIN_POINTS        = 20;
	localparam int QUEUE_DEPTH           = 2;

	localparam logic [1:0] CFG_TICK_PERIOD   = 2'd0;
	localparam logic [1:0] CFG_AVG_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_SOURCE_RATE   = 2'd2;

	localparam logic [31:0]       TICK_PERIOD_RST = 32'd95443718;
	localparam logic [31:0]       AVG_THRESH_RST  = 32'd0;
	localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd44100;

	// ms / 1000 as (ms * DIV1000_MAGIC) >> 38, exact over 32 bits
	localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
	localparam logic [9:0]  MS_PER_S      = 10'd1000;
	// r * 2^32 / 1000 = r * 4294967 + r * 37 / 125
	localparam logic [22:0] FRAC_WHOLE    = 23'd4294967;
	localparam logic [5:0]  FRAC_NUM      = 6'd37;
	// x / 125 as (x * DIV125_MAGIC) >> 24, exact for x < 37000
	localparam logic [17:0] DIV125_MAGIC  = 18'd134218;
	// x / 10 as (x * DIV10_MAGIC) >> 23, exact for x < 2^22
	localparam logic [19:0] DIV10_MAGIC   = 20'd838861;

	localparam logic [62:0]        EXPECTED_LIMIT = 63'h4000_0000_0000_0000;
	localparam logic [DIFF_W-1:0]  SYNC_LIMIT     = 48'd42949673;
	localparam logic signed [16:0] WEIGHT_Q16     = 17'sd52057;
	localparam logic [13:0]        ONE_MINUS_W    = 14'd13479;
	localparam logic [OUT_W-1:0]   OUT_MAX        = 14'd16383;

	typedef struct packed {
		logic [31:0]       tick_period;
		logic [31:0]       avg_threshold;
		logic [RATE_W-1:0] source_rate;
	} cfg_t;

endpackage

[rtl/asc_fifo.sv]
// Short register queue between the front and back parts.
// Depends on asc_pkg for the default depth.
`timescale 1ns / 1ps

module asc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = asc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	import asc_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_fifo_level: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue level beyond depth");

	a_fifo_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

[rtl/asc_front.sv]
// Front part: accepts frame words, forms the clipped drift and classifies it.
// Depends on asc_pkg; feeds asc_fifo.
`timescale 1ns / 1ps

module asc_front #(
	parameter int  MAX_FRAME_SAMPLES = asc_pkg::DEF_MAX_FRAME_SAMPLES,
	localparam int NW = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [asc_pkg::TS_W-1:0]         frame_timestamp,
	input  logic [asc_pkg::MS_W-1:0]         elapsed_ms,
	input  logic [asc_pkg::FRM_W-1:0]        frame_samples,
	input  logic [31:0]                      tick_period,
	output logic                             q_push,
	input  logic                             q_full,
	output logic signed [asc_pkg::DIFF_W-1:0] q_diff,
	output logic                             q_small,
	output logic [NW-1:0]                    q_n
);
	import asc_pkg::*;

	localparam int NCMP_W = 18;

	typedef enum logic [3:0] {
		F_IDLE, F_MUL_LO, F_MUL_HI, F_DIV_K, F_REM, F_FRAC, F_FRAC_FIX, F_ELAPSED, F_PUSH
	} state_t;

	state_t        state_q;
	logic [TS_W-1:0] ts_q;
	logic [MS_W-1:0] ms_q;
	logic [NW-1:0]   n_q;
	logic [63:0]     a_q;
	logic [39:0]     b_q;
	logic [22:0]     k_q;
	logic [9:0]      r_q;
	logic [62:0]     exp_q;
	logic [31:0]     fr_q;
	logic [15:0]     x_q;
	logic [8:0]      g_q;
	logic [54:0]     el_q;

	logic              take;
	logic [NCMP_W-1:0] n_wide;
	logic [63:0]       a_next;
	logic [39:0]       b_next;
	logic [60:0]       k_prod;
	logic [31:0]       k_x1000;
	logic [64:0]       exp_sum;
	logic [62:0]       exp_next;
	logic [32:0]       g_prod;
	logic [54:0]       el_next;
	logic signed [63:0] diff_full;
	logic [DIFF_W-1:0] diff_mag;

	assign in_stall = !((state_q == F_IDLE) || (state_q == F_PUSH && !q_full));
	assign take     = in_valid && !in_stall;

	assign n_wide = (NCMP_W'(frame_samples) > NCMP_W'(MAX_FRAME_SAMPLES)) ?
		NCMP_W'(MAX_FRAME_SAMPLES) : NCMP_W'(frame_samples);

	assign a_next  = 64'(ts_q[31:0]) * 64'(tick_period);
	assign b_next  = 40'(ts_q[39:32]) * 40'(tick_period);
	assign k_prod  = 61'(ms_q) * 61'(DIV1000_MAGIC);
	assign k_x1000 = 32'(33'(k_q) * 33'(MS_PER_S));
	assign exp_sum = {3'b000, b_q[29:0], 32'd0} + {1'b0, a_q};
	assign exp_next = ((b_q[39:30] != '0) || (exp_sum > 65'(EXPECTED_LIMIT))) ?
		EXPECTED_LIMIT : exp_sum[62:0];
	assign g_prod  = 33'(x_q) * 33'(DIV125_MAGIC);
	assign el_next = {k_q, 32'd0} + 55'(fr_q) + 55'(g_q);

	assign diff_full = $signed({1'b0, exp_q}) - $signed({9'd0, el_q});

	always_comb begin
		if (!diff_full[63] && (diff_full[62:47] != '0)) begin
			q_diff = {1'b0, {(DIFF_W - 1){1'b1}}};
		end else if (diff_full[63] && (diff_full[62:47] != '1)) begin
			q_diff = {1'b1, {(DIFF_W - 1){1'b0}}};
		end else begin
			q_diff = diff_full[DIFF_W-1:0];
		end
		diff_mag = q_diff[DIFF_W-1] ? (~q_diff + 1'b1) : q_diff;
	end

	assign q_small = (diff_mag < SYNC_LIMIT);
	assign q_n     = n_q;
	assign q_push  = (state_q == F_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			if (take) begin
				ts_q <= frame_timestamp;
				ms_q <= elapsed_ms;
				n_q  <= n_wide[NW-1:0];
			end
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) state_q <= F_MUL_LO;
				end
				F_MUL_LO: begin
					a_q     <= a_next;
					state_q <= F_MUL_HI;
				end
				F_MUL_HI: begin
					b_q     <= b_next;
					state_q <= F_DIV_K;
				end
				F_DIV_K: begin
					k_q     <= k_prod[60:38];
					state_q <= F_REM;
				end
				F_REM: begin
					r_q     <= 10'(ms_q - k_x1000);
					exp_q   <= exp_next;
					state_q <= F_FRAC;
				end
				F_FRAC: begin
					fr_q    <= 32'(33'(r_q) * 33'(FRAC_WHOLE));
					x_q     <= 16'(r_q) * 16'(FRAC_NUM);
					state_q <= F_FRAC_FIX;
				end
				F_FRAC_FIX: begin
					g_q     <= g_prod[32:24];
					state_q <= F_ELAPSED;
				end
				F_ELAPSED: begin
					el_q    <= el_next;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) state_q <= in_valid ? F_MUL_LO : F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	a_front_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

endmodule

[rtl/asc_back.sv]
// Back part: updates the weighted drift sum and point count, applies the
// sample correction and holds the result word. Depends on asc_pkg.
`timescale 1ns / 1ps

module asc_back #(
	parameter int  MAX_FRAME_SAMPLES = asc_pkg::DEF_MAX_FRAME_SAMPLES,
	parameter int  MIN_POINTS        = asc_pkg::DEF_MIN_POINTS,
	localparam int NW = $clog2(MAX_FRAME_SAMPLES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic signed [asc_pkg::DIFF_W-1:0] q_diff,
	input  logic                              q_small,
	input  logic [NW-1:0]                     q_n,
	input  logic [31:0]                       avg_threshold,
	input  logic [asc_pkg::RATE_W-1:0]        source_rate,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [asc_pkg::OUT_W-1:0]         sample_count,
	output logic                              corrected,
	output logic                              drift_reset
);
	import asc_pkg::*;

	localparam int CW    = $clog2(MIN_POINTS + 1);
	localparam int R_W   = ((NW > 34) ? NW : 34) + 2;
	localparam int SAT_W = ((NW + 1 > OUT_W) ? NW + 1 : OUT_W) + 1;

	typedef enum logic [2:0] {
		B_IDLE, B_MUL_W, B_UPDATE, B_AVG, B_CORR, B_LIMIT, B_CLIP, B_OUT
	} state_t;

	state_t                   state_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [NW-1:0]            n_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CW-1:0]            count_q;
	logic signed [72:0]       p_q;
	logic [SUM_W-1:0]         mag_q;
	logic [DIFF_W-1:0]        dmag_q;
	logic [33:0]              cm_q;
	logic [NW:0]              lo_q;
	logic [NW:0]              hi_q;
	logic [OUT_W-1:0]         res_q;
	logic                     corr_q;
	logic                     clr_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_samples_q;
	logic                     out_corr_q;
	logic                     out_clr_q;

	logic signed [72:0]       p_next;
	logic signed [57:0]       s_wide;
	logic signed [SUM_W-1:0]  s_sat;
	logic [CW-1:0]            count_next;
	logic [69:0]              avg_prod;
	logic [65:0]              cm_prod;
	logic [NW+3:0]            n9;
	logic [NW+3:0]            n11;
	logic [NW+23:0]           lo_prod;
	logic [NW+23:0]           hi_prod;
	logic signed [R_W-1:0]    r_val;
	logic signed [R_W-1:0]    lo_s;
	logic signed [R_W-1:0]    hi_s;
	logic [NW:0]              clip;
	logic [OUT_W-1:0]         clip_sat;
	logic [OUT_W-1:0]         n_sat;
	logic                     out_free;

	assign p_next = sum_q * WEIGHT_Q16;
	assign s_wide = {{(58 - DIFF_W){diff_q[DIFF_W-1]}}, diff_q} + {p_q[72], p_q[72:16]};

	always_comb begin
		if (s_wide[57:55] == 3'b000 || s_wide[57:55] == 3'b111) begin
			s_sat = s_wide[SUM_W-1:0];
		end else if (s_wide[57]) begin
			s_sat = {1'b1, {(SUM_W - 1){1'b0}}};
		end else begin
			s_sat = {1'b0, {(SUM_W - 1){1'b1}}};
		end
	end

	assign count_next = (count_q < CW'(MIN_POINTS)) ? count_q + 1'b1 : count_q;

	assign avg_prod = 70'(mag_q) * 70'(ONE_MINUS_W);
	assign cm_prod  = 66'(dmag_q) * 66'(source_rate);
	assign n9       = (NW + 4)'(n_q) * (NW + 4)'(9);
	assign n11      = (NW + 4)'(n_q) * (NW + 4)'(11);
	assign lo_prod  = (NW + 24)'(n9) * (NW + 24)'(DIV10_MAGIC);
	assign hi_prod  = (NW + 24)'(n11) * (NW + 24)'(DIV10_MAGIC);

	assign r_val = diff_q[DIFF_W-1] ? (R_W'(n_q) - R_W'(cm_q)) : (R_W'(n_q) + R_W'(cm_q));
	assign lo_s  = R_W'(lo_q);
	assign hi_s  = R_W'(hi_q);

	always_comb begin
		if (r_val < lo_s) begin
			clip = lo_q;
		end else if (r_val > hi_s) begin
			clip = hi_q;
		end else begin
			clip = r_val[NW:0];
		end
		clip_sat = (SAT_W'(clip) > SAT_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(clip);
		n_sat    = (SAT_W'(n_q) > SAT_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(n_q);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == B_IDLE) && !q_empty;

	assign out_valid    = out_valid_q;
	assign sample_count = out_samples_q;
	assign corrected    = out_corr_q;
	assign drift_reset  = out_clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						diff_q <= q_diff;
						n_q    <= q_n;
						corr_q <= 1'b0;
						if (q_small) begin
							clr_q   <= 1'b0;
							state_q <= B_MUL_W;
						end else begin
							clr_q   <= 1'b1;
							sum_q   <= '0;
							count_q <= '0;
							state_q <= B_OUT;
						end
					end
				end
				B_MUL_W: begin
					p_q     <= p_next;
					state_q <= B_UPDATE;
				end
				B_UPDATE: begin
					sum_q   <= s_sat;
					count_q <= count_next;
					mag_q   <= s_sat[SUM_W-1] ? (~s_sat + 1'b1) : s_sat;
					dmag_q  <= diff_q[DIFF_W-1] ? (~diff_q + 1'b1) : diff_q;
					state_q <= (count_next >= CW'(MIN_POINTS)) ? B_AVG : B_OUT;
				end
				B_AVG: begin
					state_q <= (avg_prod[69:16] >= 54'(avg_threshold)) ? B_CORR : B_OUT;
				end
				B_CORR: begin
					cm_q    <= cm_prod[65:32];
					state_q <= B_LIMIT;
				end
				B_LIMIT: begin
					lo_q    <= lo_prod[NW+23:23];
					hi_q    <= hi_prod[NW+23:23];
					state_q <= B_CLIP;
				end
				B_CLIP: begin
					res_q   <= clip_sat;
					corr_q  <= 1'b1;
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						out_samples_q <= corr_q ? res_q : n_sat;
						out_corr_q    <= corr_q;
						out_clr_q     <= clr_q;
						state_q       <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_back_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MIN_POINTS))
		else $error("point count beyond saturation");

	a_back_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_corr_q && out_clr_q))
		else $error("correction and drift clear in one word");

endmodule

[rtl/audio_sync_sample_compensator.sv]
// Top level of the audio sync sample compensator: configuration registers,
// front part, queue and back part. Depends on asc_pkg, asc_front, asc_fifo, asc_back.
`timescale 1ns / 1ps

// Takes one word per decoded audio frame (timestamp in ticks, wall clock in ms,
// sample count) and returns one word with the sample count to produce, corrected
// for clock drift once enough small-drift frames have been averaged and their
// average reaches the averaging threshold. The front part runs its multiply and
// divide-by-1000 sequence on each word and takes the next word in the cycle its
// result enters a two-entry queue, so it can work on a new word while the back
// part forms the weighted sum and the correction multiplies for the last one.
// Configuration registers (tick period, averaging threshold, source rate) are
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while no word is in flight, as the block itself does not enforce this.
// Unknown indexes are ignored.
module audio_sync_sample_compensator #(
	parameter int MAX_FRAME_SAMPLES = asc_pkg::DEF_MAX_FRAME_SAMPLES,
	parameter int MIN_POINTS        = asc_pkg::DEF_MIN_POINTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [asc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [asc_pkg::TS_W-1:0]    frame_timestamp,
	input  logic [asc_pkg::MS_W-1:0]    elapsed_ms,
	input  logic [asc_pkg::FRM_W-1:0]   frame_samples,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [asc_pkg::OUT_W-1:0]   sample_count,
	output logic                        corrected,
	output logic                        drift_reset
);
	import asc_pkg::*;

	localparam int NW  = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int Q_W = 1 + DIFF_W + NW;

	cfg_t cfg_q;

	logic                     q_push;
	logic                     q_pop;
	logic                     q_full;
	logic                     q_empty;
	logic signed [DIFF_W-1:0] f_diff;
	logic                     f_small;
	logic [NW-1:0]            f_n;
	logic [Q_W-1:0]           q_wr;
	logic [Q_W-1:0]           q_rd;
	logic signed [DIFF_W-1:0] b_diff;
	logic                     b_small;
	logic [NW-1:0]            b_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period   <= TICK_PERIOD_RST;
			cfg_q.avg_threshold <= AVG_THRESH_RST;
			cfg_q.source_rate   <= SOURCE_RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TICK_PERIOD:   cfg_q.tick_period   <= cfg_data;
				CFG_AVG_THRESHOLD: cfg_q.avg_threshold <= cfg_data;
				CFG_SOURCE_RATE:   cfg_q.source_rate   <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	asc_front #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_timestamp(frame_timestamp),
		.elapsed_ms     (elapsed_ms),
		.frame_samples  (frame_samples),
		.tick_period    (cfg_q.tick_period),
		.q_push         (q_push),
		.q_full         (q_full),
		.q_diff         (f_diff),
		.q_small        (f_small),
		.q_n            (f_n)
	);

	assign q_wr = {f_small, f_diff, f_n};

	asc_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data(q_wr),
		.pop    (q_pop),
		.rd_data(q_rd),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign b_small = q_rd[Q_W-1];
	assign b_diff  = q_rd[Q_W-2:NW];
	assign b_n     = q_rd[NW-1:0];

	asc_back #(
		.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
		.MIN_POINTS       (MIN_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_diff       (b_diff),
		.q_small      (b_small),
		.q_n          (b_n),
		.avg_threshold(cfg_q.avg_threshold),
		.source_rate  (cfg_q.source_rate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_count (sample_count),
		.corrected    (corrected),
		.drift_reset  (drift_reset)
	);

endmodule
